FILE: sv/vrlo_pkg.sv
// Shared types and constants for the voxel ray log-odds update block.
// Used by every module of the block but vrlo_div; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package vrlo_pkg;

   localparam int COORD_W = 10;   // holds any voxel coordinate up to 2*512-1
   localparam int CFG_IDX_W = 3;
   localparam logic CMD_RAY = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_CENTRE_X, CFG_CENTRE_Y, CFG_CENTRE_Z, CFG_SIZE_XY,
      CFG_SIZE_Z, CFG_FREE_DELTA, CFG_OCC_DELTA, CFG_MARGIN
   } cfg_index_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_ORIGIN_OUT = 2'd1,
      ST_POINT_OUT  = 2'd2
   } status_type;

   typedef enum logic [1:0] {JOB_RAY, JOB_READ, JOB_NONE} job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      status_type         status;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      logic [COORD_W-1:0] oz;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] pz;
   } job_type;

   typedef struct packed {
      logic signed [15:0] centre_x;
      logic signed [15:0] centre_y;
      logic signed [15:0] centre_z;
      logic [9:0]         size_xy;
      logic [9:0]         size_z;
   } front_cfg_type;

   typedef struct packed {
      logic signed [15:0] free_delta;
      logic signed [15:0] occupied_delta;
      logic [7:0]         margin;
   } back_cfg_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         steps_marked;
      logic [15:0]        pass_count;
      logic [15:0]        reflect_count;
      logic signed [15:0] odds_q88;
   } result_type;

   typedef enum logic [1:0] {F_IDLE, F_DIV_START, F_DIV_WAIT, F_ENQ} front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_SETUP, B_SUM, B_SQRT, B_PLAN, B_WALK_RD, B_WALK_WR,
      B_HIT_RD, B_HIT_WR, B_READ_RD, B_READ_CAP, B_DONE
   } back_state_type;

endpackage
`default_nettype wire

FILE: sv/vrlo_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module vrlo_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] mag_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W:0]   rem_nx;

   always_comb begin
      rem_sh = {rem_ff, mag_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_nx = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && run_ff && (cnt_ff == CNT_W'(NUM_W - 1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            neg_ff <= num[NUM_W-1];
            mag_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_ff <= '0;
            den_ff <= den;
         end else if (run_ff) begin
            mag_ff <= {mag_ff[NUM_W-2:0], ge};
            rem_ff <= rem_nx[DEN_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) run_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
endmodule
`default_nettype wire

FILE: sv/vrlo_front.sv
// Front end: accepts commands, converts millimetres to voxel indices, classifies.
// Depends on vrlo_pkg and vrlo_div.
`timescale 1ns / 1ps
`default_nettype none
module vrlo_front import vrlo_pkg::*; #(
   parameter int HALF_XY = 64,
   parameter int HALF_Z  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_cmd,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic signed [15:0] req_origin_z,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic [6:0]         req_read_x,
   input  logic [6:0]         req_read_y,
   input  logic [4:0]         req_read_z,
   input  front_cfg_type      cfg,
   input  logic               clear_busy,
   output job_type            job,
   output logic               job_push,
   input  logic               job_full
);
   localparam int DIM_XY   = 2 * HALF_XY;
   localparam int DIM_Z    = 2 * HALF_Z;
   localparam int HALF_MAX = (HALF_XY > HALF_Z) ? HALF_XY : HALF_Z;
   localparam int NUM_W    = $clog2(HALF_MAX * 1023 + 65536) + 1;

   front_state_type         state_ff, state_in;
   logic                    cmd_ff;
   logic [6:0]              rx_ff, ry_ff;
   logic [4:0]              rz_ff;
   logic signed [15:0]      pos_ff [6];
   logic signed [NUM_W-1:0] idx_ff [6];
   logic [2:0]              k_ff;
   logic                    accept;
   logic                    div_start;
   logic                    div_done;
   logic signed [NUM_W-1:0] div_quo;
   logic                    axis_z;
   logic signed [15:0]      centre_sel;
   logic [9:0]              size_sel;
   logic [9:0]              size_eff;
   logic [NUM_W-1:0]        half_sel;
   logic signed [16:0]      diff;
   logic signed [NUM_W-1:0] num;
   logic                    o_in, p_in, r_in;

   assign accept = push && !full;

   // operands of the current conversion
   always_comb begin
      axis_z     = (k_ff == 3'd2) || (k_ff == 3'd5);
      centre_sel = (k_ff == 3'd0 || k_ff == 3'd3) ? cfg.centre_x :
                   (k_ff == 3'd1 || k_ff == 3'd4) ? cfg.centre_y : cfg.centre_z;
      size_sel   = axis_z ? cfg.size_z : cfg.size_xy;
      size_eff   = (size_sel == 10'd0) ? 10'd1 : size_sel;
      half_sel   = axis_z ? NUM_W'(HALF_Z) : NUM_W'(HALF_XY);
      diff       = 17'(pos_ff[k_ff]) - 17'(centre_sel);
      num        = $signed(half_sel * NUM_W'(size_eff)) + NUM_W'(diff);
   end

   vrlo_div #(.NUM_W(NUM_W), .DEN_W(10)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (size_eff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = (req_cmd == CMD_READ) ? F_ENQ : F_DIV_START;
         end
         F_DIV_START: state_in = F_DIV_WAIT;
         F_DIV_WAIT: begin
            if (div_done) state_in = (k_ff == 3'd5) ? F_ENQ : F_DIV_START;
         end
         F_ENQ: begin
            if (!job_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      full      = (state_ff != F_IDLE) || clear_busy;
      div_start = (state_ff == F_DIV_START);
      job_push  = (state_ff == F_ENQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_IDLE && accept) begin
            cmd_ff    <= req_cmd;
            rx_ff     <= req_read_x;
            ry_ff     <= req_read_y;
            rz_ff     <= req_read_z;
            pos_ff[0] <= req_origin_x;
            pos_ff[1] <= req_origin_y;
            pos_ff[2] <= req_origin_z;
            pos_ff[3] <= req_point_x;
            pos_ff[4] <= req_point_y;
            pos_ff[5] <= req_point_z;
            k_ff      <= '0;
         end
         if (state_ff == F_DIV_WAIT && div_done) begin
            idx_ff[k_ff] <= div_quo;
            k_ff         <= k_ff + 1'b1;
         end
      end
   end

   // classify: origin tested before hit point
   always_comb begin
      o_in = (idx_ff[0] >= 0) && (idx_ff[0] < NUM_W'(DIM_XY)) &&
             (idx_ff[1] >= 0) && (idx_ff[1] < NUM_W'(DIM_XY)) &&
             (idx_ff[2] >= 0) && (idx_ff[2] < NUM_W'(DIM_Z));
      p_in = (idx_ff[3] >= 0) && (idx_ff[3] < NUM_W'(DIM_XY)) &&
             (idx_ff[4] >= 0) && (idx_ff[4] < NUM_W'(DIM_XY)) &&
             (idx_ff[5] >= 0) && (idx_ff[5] < NUM_W'(DIM_Z));
      r_in = (int'(rx_ff) < DIM_XY) && (int'(ry_ff) < DIM_XY) && (int'(rz_ff) < DIM_Z);
      if (cmd_ff == CMD_READ) begin
         job.kind   = r_in ? JOB_READ : JOB_NONE;
         job.status = ST_DONE;
         job.ox     = COORD_W'(rx_ff);
         job.oy     = COORD_W'(ry_ff);
         job.oz     = COORD_W'(rz_ff);
         job.px     = '0;
         job.py     = '0;
         job.pz     = '0;
      end else begin
         job.kind   = (o_in && p_in) ? JOB_RAY : JOB_NONE;
         job.status = !o_in ? ST_ORIGIN_OUT : (!p_in ? ST_POINT_OUT : ST_DONE);
         job.ox     = COORD_W'(idx_ff[0]);
         job.oy     = COORD_W'(idx_ff[1]);
         job.oz     = COORD_W'(idx_ff[2]);
         job.px     = COORD_W'(idx_ff[3]);
         job.py     = COORD_W'(idx_ff[4]);
         job.pz     = COORD_W'(idx_ff[5]);
      end
   end
endmodule
`default_nettype wire

FILE: sv/vrlo_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on vrlo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrlo_queue import vrlo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    q_full,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    q_empty
);
   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (wr_en && !q_full) begin
            entry_ff[wr_ptr_ff] <= wr_data;
            wr_ptr_ff           <= !wr_ptr_ff;
         end
         if (rd_en && !q_empty) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(wr_en && !q_full) - 2'(rd_en && !q_empty);
      end
   end
endmodule
`default_nettype wire

FILE: sv/vrlo_back.sv
// Back end: voxel store, clearing pass, integer square root, ray walk, results.
// Depends on vrlo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrlo_back import vrlo_pkg::*; #(
   parameter int HALF_XY    = 64,
   parameter int HALF_Z     = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  back_cfg_type cfg,
   input  job_type      job,
   input  logic         job_empty,
   output logic         job_pop,
   output logic         clear_busy,
   output result_type   rsp,
   output logic         empty,
   input  logic         pop
);
   localparam int DIM_XY = 2 * HALF_XY;
   localparam int DIM_Z  = 2 * HALF_Z;
   localparam int CELLS  = DIM_XY * DIM_XY * DIM_Z;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int XY_W   = $clog2(DIM_XY);
   localparam int Z_W    = $clog2(DIM_Z);
   localparam int C_W    = (XY_W > Z_W) ? XY_W : Z_W;
   localparam int D_W    = C_W + 1;
   localparam int DMAX   = (DIM_XY > DIM_Z) ? DIM_XY : DIM_Z;
   localparam int S_W    = $clog2(3 * (DMAX - 1) * (DMAX - 1) + 1);
   localparam int SQ_W   = S_W + (S_W % 2);
   localparam int N_W    = SQ_W / 2;
   localparam int R_W    = N_W + 2;
   localparam int M_W    = (N_W > 8) ? N_W : 8;
   localparam int IT_W   = $clog2(N_W + 1);
   localparam int CNT_W  = (COUNT_BITS > 16) ? 16 : COUNT_BITS;
   localparam int ENT_W  = 2 * CNT_W + 16;

   back_state_type        state_ff, state_in;
   logic [ENT_W-1:0]      mem [CELLS];
   logic [ENT_W-1:0]      rd_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [ENT_W-1:0]      mem_wdata;
   job_type               job_ff;
   logic [C_W-1:0]        q_ff [3];
   logic signed [D_W-1:0] d_ff [3];
   logic signed [R_W-1:0] r_ff [3];
   logic [SQ_W-1:0]       sq_ff [3];
   logic [SQ_W-1:0]       v_ff, root_ff, bit_ff;
   logic [IT_W-1:0]       it_ff;
   logic [N_W-1:0]        n_ff;
   logic [N_W-1:0]        walk_ff;
   logic [7:0]            marked_ff;
   logic [ADDR_W-1:0]     clr_ff;
   result_type            pend_ff, res_ff;
   logic                  res_valid_ff;
   logic [SQ_W-1:0]       trial;
   logic [M_W-1:0]        walk_len;
   logic [C_W-1:0]        ax, ay, az;
   logic [CNT_W-1:0]      pass_cur, refl_cur;
   logic signed [15:0]    odds_cur, odds_delta;
   logic signed [16:0]    odds_sum;
   logic signed [15:0]    odds_new;
   logic [CNT_W-1:0]      pass_new, refl_new;
   logic signed [R_W-1:0] rn [3];
   logic signed [R_W-1:0] r_nx [3];
   logic [C_W-1:0]        q_nx [3];
   logic signed [2*D_W-1:0] sq_full [3];

   // voxel store: one port, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   always_comb begin
      pass_cur   = rd_ff[ENT_W-1 -: CNT_W];
      refl_cur   = rd_ff[16 +: CNT_W];
      odds_cur   = $signed(rd_ff[15:0]);
      pass_new   = (pass_cur == {CNT_W{1'b1}}) ? pass_cur : pass_cur + 1'b1;
      refl_new   = (refl_cur == {CNT_W{1'b1}}) ? refl_cur : refl_cur + 1'b1;
      odds_delta = (state_ff == B_HIT_WR) ? cfg.occupied_delta : cfg.free_delta;
      odds_sum   = 17'(odds_cur) + 17'(odds_delta);
      if (odds_sum[16] != odds_sum[15]) odds_new = odds_sum[16] ? 16'sh8000 : 16'sh7FFF;
      else odds_new = odds_sum[15:0];
   end

   // next coordinate along the line: one correction keeps the remainder in [0, n)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_full[i] = d_ff[i] * d_ff[i];
         rn[i]      = r_ff[i] + R_W'(d_ff[i]);
         if (rn[i] >= $signed(R_W'(n_ff))) begin
            r_nx[i] = rn[i] - $signed(R_W'(n_ff));
            q_nx[i] = q_ff[i] + 1'b1;
         end else if (rn[i] < 0) begin
            r_nx[i] = rn[i] + $signed(R_W'(n_ff));
            q_nx[i] = q_ff[i] - 1'b1;
         end else begin
            r_nx[i] = rn[i];
            q_nx[i] = q_ff[i];
         end
      end
      trial    = root_ff + bit_ff;
      walk_len = (M_W'(root_ff[N_W-1:0]) > M_W'(cfg.margin)) ?
                 M_W'(root_ff[N_W-1:0]) - M_W'(cfg.margin) : '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR:    if (clr_ff == ADDR_W'(CELLS - 1)) state_in = B_IDLE;
         B_IDLE: begin
            if (!job_empty) begin
               case (job.kind)
                  JOB_RAY:  state_in = B_SETUP;
                  JOB_READ: state_in = B_READ_RD;
                  default:  state_in = B_DONE;
               endcase
            end
         end
         B_SETUP:    state_in = B_SUM;
         B_SUM:      state_in = B_SQRT;
         B_SQRT:     if (it_ff == IT_W'(N_W - 1)) state_in = B_PLAN;
         B_PLAN:     state_in = (walk_len == '0) ? B_HIT_RD : B_WALK_RD;
         B_WALK_RD:  state_in = B_WALK_WR;
         B_WALK_WR:  state_in = (walk_ff == N_W'(1)) ? B_HIT_RD : B_WALK_RD;
         B_HIT_RD:   state_in = B_HIT_WR;
         B_HIT_WR:   state_in = B_DONE;
         B_READ_RD:  state_in = B_READ_CAP;
         B_READ_CAP: state_in = B_DONE;
         B_DONE:     if (!res_valid_ff || pop) state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_pop    = (state_ff == B_IDLE) && !job_empty;
      clear_busy = (state_ff == B_CLEAR);
      mem_we     = (state_ff == B_CLEAR) || (state_ff == B_WALK_WR) ||
                   (state_ff == B_HIT_WR);
      case (state_ff)
         B_WALK_RD, B_WALK_WR: begin
            ax = q_ff[0]; ay = q_ff[1]; az = q_ff[2];
         end
         B_HIT_RD, B_HIT_WR: begin
            ax = C_W'(job_ff.px); ay = C_W'(job_ff.py); az = C_W'(job_ff.pz);
         end
         default: begin
            ax = C_W'(job_ff.ox); ay = C_W'(job_ff.oy); az = C_W'(job_ff.oz);
         end
      endcase
      if (state_ff == B_CLEAR) mem_addr = clr_ff;
      else mem_addr = ADDR_W'((ADDR_W'(ax) * ADDR_W'(DIM_XY) + ADDR_W'(ay)) *
                              ADDR_W'(DIM_Z) + ADDR_W'(az));
      case (state_ff)
         B_WALK_WR: mem_wdata = {pass_new, refl_cur, odds_new};
         B_HIT_WR:  mem_wdata = {pass_cur, refl_new, odds_new};
         default:   mem_wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // load the result slot on completion, else drop it once popped
         if (state_ff == B_DONE && (!res_valid_ff || pop)) begin
            res_ff       <= pend_ff;
            res_valid_ff <= 1'b1;
         end else if (pop && res_valid_ff) begin
            res_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_CLEAR: clr_ff <= clr_ff + 1'b1;
            B_IDLE: begin
               if (!job_empty) begin
                  job_ff  <= job;
                  q_ff[0] <= C_W'(job.ox);
                  q_ff[1] <= C_W'(job.oy);
                  q_ff[2] <= C_W'(job.oz);
                  d_ff[0] <= $signed({1'b0, C_W'(job.px)}) - $signed({1'b0, C_W'(job.ox)});
                  d_ff[1] <= $signed({1'b0, C_W'(job.py)}) - $signed({1'b0, C_W'(job.oy)});
                  d_ff[2] <= $signed({1'b0, C_W'(job.pz)}) - $signed({1'b0, C_W'(job.oz)});
                  pend_ff <= '{status: job.status, steps_marked: '0, pass_count: '0,
                               reflect_count: '0, odds_q88: '0};
               end
            end
            B_SETUP: begin
               for (int i = 0; i < 3; i++) sq_ff[i] <= SQ_W'(sq_full[i]);
            end
            B_SUM: begin
               v_ff    <= SQ_W'(sq_ff[0] + sq_ff[1] + sq_ff[2]);
               root_ff <= '0;
               bit_ff  <= SQ_W'(1) << (SQ_W - 2);
               it_ff   <= '0;
            end
            B_SQRT: begin
               if (v_ff >= trial) begin
                  v_ff    <= v_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               it_ff  <= it_ff + 1'b1;
            end
            B_PLAN: begin
               n_ff      <= root_ff[N_W-1:0];
               walk_ff   <= N_W'(walk_len);
               marked_ff <= (walk_len > M_W'(255)) ? 8'd255 : 8'(walk_len);
               for (int i = 0; i < 3; i++) r_ff[i] <= '0;
            end
            B_WALK_WR: begin
               walk_ff <= walk_ff - 1'b1;
               for (int i = 0; i < 3; i++) begin
                  q_ff[i] <= q_nx[i];
                  r_ff[i] <= r_nx[i];
               end
            end
            B_HIT_WR: begin
               pend_ff <= '{status: pend_ff.status, steps_marked: marked_ff,
                            pass_count: pend_ff.pass_count,
                            reflect_count: pend_ff.reflect_count,
                            odds_q88: pend_ff.odds_q88};
            end
            B_READ_CAP: begin
               pend_ff <= '{status: pend_ff.status, steps_marked: pend_ff.steps_marked,
                            pass_count: 16'(pass_cur), reflect_count: 16'(refl_cur),
                            odds_q88: odds_cur};
            end
            default: ;
         endcase
      end
   end

   assign rsp   = res_ff;
   assign empty = !res_valid_ff;

   a_no_job_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !job_pop)
      else $error("job taken during clearing pass");

   a_walk_in_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WALK_WR) |->
         (int'(q_ff[0]) < DIM_XY) && (int'(q_ff[1]) < DIM_XY) && (int'(q_ff[2]) < DIM_Z))
      else $error("ray walk left the map");

   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WALK_RD) |->
         (r_ff[0] >= 0) && (r_ff[0] < $signed(R_W'(n_ff))) &&
         (r_ff[2] >= 0) && (r_ff[2] < $signed(R_W'(n_ff))))
      else $error("walk remainder out of range");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(res_valid_ff) |-> $past(state_ff == B_DONE))
      else $error("result loaded outside completion state");
endmodule
`default_nettype wire

FILE: sv/voxel_ray_log_odds_update.sv
// Ray command: the front end converts the six coordinates one after another through
// the divider; the back end is bound by the single voxel store port doing a read then
// a write per voxel. Front and back overlap through a two-entry job queue; one item at
// a time per part. Reset (synchronous, active high) clears control and starts a clearing
// pass over all 2*HALF_XY * 2*HALF_XY * 2*HALF_Z voxels (524288 by default); full stays
// high while it runs.
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_log_odds_update import vrlo_pkg::*; #(
   parameter int HALF_XY    = 64,
   parameter int HALF_Z     = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // command side
   input  logic                 push,
   output logic                 full,
   input  logic                 req_cmd,
   input  logic signed [15:0]   req_origin_x,
   input  logic signed [15:0]   req_origin_y,
   input  logic signed [15:0]   req_origin_z,
   input  logic signed [15:0]   req_point_x,
   input  logic signed [15:0]   req_point_y,
   input  logic signed [15:0]   req_point_z,
   input  logic [6:0]           req_read_x,
   input  logic [6:0]           req_read_y,
   input  logic [4:0]           req_read_z,
   // result side
   output logic                 empty,
   input  logic                 pop,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_steps_marked,
   output logic [15:0]          rsp_pass_count,
   output logic [15:0]          rsp_reflect_count,
   output logic signed [15:0]   rsp_odds_q88,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);
   front_cfg_type front_cfg_ff;
   back_cfg_type  back_cfg_ff;
   job_type       fq_job, bq_job;
   logic          fq_push, fq_full, bq_pop, bq_empty;
   logic          clear_busy;
   result_type    rsp;

   // Registers take a write in any cycle; software writes them only while idle (not enforced here).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.centre_x     <= '0;
         front_cfg_ff.centre_y     <= '0;
         front_cfg_ff.centre_z     <= '0;
         front_cfg_ff.size_xy      <= 10'd100;
         front_cfg_ff.size_z       <= 10'd50;
         back_cfg_ff.free_delta     <= -16'sd102;
         back_cfg_ff.occupied_delta <= 16'sd218;
         back_cfg_ff.margin         <= '0;
      end else if (csr_valid && csr_ready) begin
         case (cfg_index_type'(csr_index))
            CFG_CENTRE_X:   front_cfg_ff.centre_x      <= $signed(csr_wdata);
            CFG_CENTRE_Y:   front_cfg_ff.centre_y      <= $signed(csr_wdata);
            CFG_CENTRE_Z:   front_cfg_ff.centre_z      <= $signed(csr_wdata);
            CFG_SIZE_XY:    front_cfg_ff.size_xy       <= csr_wdata[9:0];
            CFG_SIZE_Z:     front_cfg_ff.size_z        <= csr_wdata[9:0];
            CFG_FREE_DELTA: back_cfg_ff.free_delta     <= $signed(csr_wdata);
            CFG_OCC_DELTA:  back_cfg_ff.occupied_delta <= $signed(csr_wdata);
            CFG_MARGIN:     back_cfg_ff.margin         <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Front end: index conversion and classification, one command at a time.
   vrlo_front #(.HALF_XY(HALF_XY), .HALF_Z(HALF_Z)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_cmd      (req_cmd),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .req_read_x   (req_read_x),
      .req_read_y   (req_read_y),
      .req_read_z   (req_read_z),
      .cfg          (front_cfg_ff),
      .clear_busy   (clear_busy),
      .job          (fq_job),
      .job_push     (fq_push),
      .job_full     (fq_full)
   );

   // Decouple the two parts so a long ray walk does not hold up conversion.
   vrlo_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fq_push),
      .wr_data (fq_job),
      .q_full  (fq_full),
      .rd_en   (bq_pop),
      .rd_data (bq_job),
      .q_empty (bq_empty)
   );

   // Back end: voxel store updates and the result register.
   vrlo_back #(.HALF_XY(HALF_XY), .HALF_Z(HALF_Z), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (back_cfg_ff),
      .job        (bq_job),
      .job_empty  (bq_empty),
      .job_pop    (bq_pop),
      .clear_busy (clear_busy),
      .rsp        (rsp),
      .empty      (empty),
      .pop        (pop)
   );

   assign rsp_status        = 2'(rsp.status);
   assign rsp_steps_marked  = rsp.steps_marked;
   assign rsp_pass_count    = rsp.pass_count;
   assign rsp_reflect_count = rsp.reflect_count;
   assign rsp_odds_q88      = rsp.odds_q88;
endmodule
`default_nettype wire
